>>> rtl/skt_pkg.sv
package skt_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic [2:0] FN_INSERT        = 3'd0;
	localparam logic [2:0] FN_INSERT_UNIQUE = 3'd1;
	localparam logic [2:0] FN_REMOVE        = 3'd2;
	localparam logic [2:0] FN_SEARCH        = 3'd3;
	localparam logic [2:0] FN_READ_AT       = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] key;
		logic [3:0]  position_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [4:0]  position;
		logic [31:0] key_out;
		logic [4:0]  occupancy;
	} rsp_t;

endpackage

>>> rtl/sorted_key_table.sv
// A request runs through S_START, a binary search of at most log2(DEPTH)+1 probes
// (S_PROBE, S_COMP each), S_RESOLVE, S_MOVE_RD and S_MOVE_WR per entry moved by an
// insert or remove, S_PUT for a completed insert, and S_DONE. Read-at runs S_START,
// S_RDAT, S_DONE; a bad index or unused code goes from S_START to S_DONE. One request
// at a time; one key memory serves every probe and move, one comparator every probe.
// Reset clears the entry count and the handshake state; the key memory is not cleared.
module sorted_key_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  skt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output skt_pkg::rsp_t rsp
);

	localparam int IDX_W = skt_pkg::IDX_W;
	localparam int CNT_W = skt_pkg::CNT_W;
	localparam int KB    = skt_pkg::KEY_BITS;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_START   = 10'b0000000010,
		S_PROBE   = 10'b0000000100,
		S_COMP    = 10'b0000001000,
		S_RESOLVE = 10'b0000010000,
		S_MOVE_RD = 10'b0000100000,
		S_MOVE_WR = 10'b0001000000,
		S_PUT     = 10'b0010000000,
		S_RDAT    = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [KB-1:0]    mem [skt_pkg::DEPTH];
	logic [KB-1:0]    rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wa;
	logic [KB-1:0]    wd;

	logic [2:0]       func_q;
	logic [KB-1:0]    key_q;
	logic [3:0]       idx_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi1_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] dst_q;
	logic             ins_q;
	logic             found_q;
	logic [2:0]       status_q;
	logic [KB-1:0]    kout_q;

	logic             rsp_valid_q;
	skt_pkg::rsp_t    rsp_q;

	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] src;
	logic [CNT_W-1:0] nlo;
	logic [CNT_W-1:0] dst_dn;
	logic [CNT_W-1:0] dst_up;
	logic             full;
	logic             idx_ok;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi1_q} - (CNT_W+1)'(1);
	assign mid     = mid_sum[CNT_W:1];
	assign nlo     = mid_q + CNT_W'(1);
	assign dst_dn  = dst_q - CNT_W'(1);
	assign dst_up  = dst_q + CNT_W'(1);
	assign src     = ins_q ? dst_dn : dst_up;
	assign full    = (count_q == CNT_W'(skt_pkg::DEPTH));
	assign idx_ok  = (CNT_W'(idx_q) < count_q);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		unique case (state_q)
			S_START:   rd_addr = idx_q[IDX_W-1:0];
			S_PROBE:   rd_addr = mid[IDX_W-1:0];
			S_MOVE_RD: rd_addr = src[IDX_W-1:0];
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = dst_q[IDX_W-1:0];
		wd = rd_data_q;
		unique case (state_q)
			S_MOVE_WR: we = 1'b1;
			S_PUT: begin
				we = 1'b1;
				wa = pos_q[IDX_W-1:0];
				wd = key_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					func_q <= req.func;
					key_q  <= req.key[KB-1:0];
					idx_q  <= req.position_in;
				end
			end
			S_START: begin
				found_q  <= 1'b0;
				status_q <= skt_pkg::ST_OK;
				kout_q   <= '0;
				pos_q    <= '0;
				lo_q     <= '0;
				hi1_q    <= count_q;
				if (func_q == skt_pkg::FN_READ_AT) begin
					pos_q <= CNT_W'(idx_q);
					if (!idx_ok)
						status_q <= skt_pkg::ST_RANGE;
				end
			end
			S_PROBE: mid_q <= mid;
			S_COMP: begin
				if (key_q > rd_data_q) begin
					lo_q  <= nlo;
					pos_q <= nlo;
				end else if (key_q < rd_data_q) begin
					hi1_q <= mid_q;
					pos_q <= mid_q;
				end else begin
					pos_q   <= mid_q;
					found_q <= 1'b1;
				end
			end
			S_RESOLVE: begin
				ins_q <= 1'b1;
				dst_q <= count_q;
				if (func_q == skt_pkg::FN_SEARCH) begin
					if (!found_q)
						status_q <= skt_pkg::ST_NOT_FOUND;
				end else if (func_q == skt_pkg::FN_REMOVE) begin
					ins_q <= 1'b0;
					dst_q <= pos_q;
					if (!found_q)
						status_q <= skt_pkg::ST_NOT_FOUND;
				end else if (func_q == skt_pkg::FN_INSERT_UNIQUE && found_q) begin
					status_q <= skt_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_q <= skt_pkg::ST_FULL;
				end
			end
			S_MOVE_WR: dst_q <= ins_q ? dst_dn : dst_up;
			S_RDAT: kout_q <= rd_data_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready))
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_START;
				end
				S_START: begin
					priority if (func_q == skt_pkg::FN_READ_AT)
						state_q <= idx_ok ? S_RDAT : S_DONE;
					else if (func_q > skt_pkg::FN_READ_AT)
						state_q <= S_DONE;
					else if (count_q == '0)
						state_q <= S_RESOLVE;
					else
						state_q <= S_PROBE;
				end
				S_PROBE: state_q <= S_COMP;
				S_COMP: begin
					if (key_q > rd_data_q)
						state_q <= (nlo >= hi1_q) ? S_RESOLVE : S_PROBE;
					else if (key_q < rd_data_q)
						state_q <= (lo_q >= mid_q) ? S_RESOLVE : S_PROBE;
					else
						state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					priority if (func_q == skt_pkg::FN_SEARCH) begin
						state_q <= S_DONE;
					end else if (func_q == skt_pkg::FN_REMOVE) begin
						if (!found_q) begin
							state_q <= S_DONE;
						end else if (pos_q + CNT_W'(1) < count_q) begin
							state_q <= S_MOVE_RD;
						end else begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_DONE;
						end
					end else if (func_q == skt_pkg::FN_INSERT_UNIQUE && found_q) begin
						state_q <= S_DONE;
					end else if (full) begin
						state_q <= S_DONE;
					end else begin
						state_q <= (count_q > pos_q) ? S_MOVE_RD : S_PUT;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					if (ins_q) begin
						state_q <= (dst_dn > pos_q) ? S_MOVE_RD : S_PUT;
					end else if (dst_up + CNT_W'(1) < count_q) begin
						state_q <= S_MOVE_RD;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_RDAT: state_q <= S_DONE;
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response beat register, loaded when the sequencer finishes
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.status    <= status_q;
			rsp_q.found     <= found_q;
			rsp_q.position  <= 5'(pos_q);
			rsp_q.key_out   <= 32'(kout_q);
			rsp_q.occupancy <= 5'(count_q);
		end
	end

endmodule

>>> rtl/skt_check.sv
module skt_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input skt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an operation is in progress");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.occupancy <= 5'(skt_pkg::DEPTH))
		else $error("occupancy beyond table depth");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |->
			(rsp.status == skt_pkg::ST_OK || rsp.status == skt_pkg::ST_DUPLICATE ||
			 rsp.status == skt_pkg::ST_FULL))
		else $error("found flag with inconsistent status");

	a_range_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == skt_pkg::ST_RANGE |-> rsp.key_out == '0)
		else $error("key returned for an index out of range");

endmodule

bind sorted_key_table skt_check u_skt_check (.*);

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FN_FIRST_UNUSED = skt_pkg::FN_READ_AT + 3'd1;
	localparam logic [2:0] FN_LAST_CODE    = 3'd7;
	localparam int         WATCHDOG_CYCLES = 2000;
	localparam int         DRAIN_CYCLES    = 60;
	localparam int         BATCHES         = 13;
	localparam int         BATCH_ITEMS     = 50;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	skt_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready;
	skt_pkg::rsp_t  rsp;

	logic [31:0]    table_keys [skt_pkg::DEPTH];
	int unsigned    table_count;
	skt_pkg::rsp_t  table_replies_due [$];
	logic [31:0]    key_pool [8];

	skt_pkg::rsp_t due_reply;
	int   fail_count;
	int   reply_count;
	int   idle_cycles;
	int   hold_cycles;
	int   calm_cycles;
	int   send_calm_items;
	int   ready_roll;

	sorted_key_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// binary search; slot is the match or the insertion point
	function automatic bit find_slot(input logic [31:0] k, output int unsigned slot);
		int lo;
		int hi;
		int mid;
		int verdict;
		if (table_count == 0) begin
			slot = 0;
			return 1'b0;
		end
		lo = 0;
		hi = int'(table_count) - 1;
		mid = 0;
		verdict = 0;
		do begin
			mid = (lo + hi) / 2;
			if (k > table_keys[mid]) begin
				verdict = 1;
				lo = mid + 1;
			end else if (k < table_keys[mid]) begin
				verdict = -1;
				hi = mid - 1;
			end else begin
				verdict = 0;
				break;
			end
		end while (hi >= lo);
		if (verdict == 1)
			mid++;
		slot = mid;
		return verdict == 0;
	endfunction

	function automatic skt_pkg::rsp_t compute_table_reply(input skt_pkg::req_t item);
		skt_pkg::rsp_t reply;
		int unsigned   slot;
		bit            hit;
		reply = '0;
		slot = 0;
		hit = 1'b0;
		case (item.func)
			skt_pkg::FN_INSERT, skt_pkg::FN_INSERT_UNIQUE, skt_pkg::FN_REMOVE,
			skt_pkg::FN_SEARCH: begin
				hit = find_slot(item.key, slot);
				if (item.func == skt_pkg::FN_INSERT_UNIQUE && hit) begin
					reply.status = skt_pkg::ST_DUPLICATE;
				end else if (item.func == skt_pkg::FN_INSERT ||
						item.func == skt_pkg::FN_INSERT_UNIQUE) begin
					if (table_count >= skt_pkg::DEPTH) begin
						reply.status = skt_pkg::ST_FULL;
					end else begin
						for (int i = int'(table_count); i > int'(slot); i--)
							table_keys[i] = table_keys[i - 1];
						table_keys[slot] = item.key;
						table_count++;
					end
				end else if (!hit) begin
					reply.status = skt_pkg::ST_NOT_FOUND;
				end else if (item.func == skt_pkg::FN_REMOVE) begin
					for (int i = int'(slot); i + 1 < int'(table_count); i++)
						table_keys[i] = table_keys[i + 1];
					table_count--;
				end
			end
			skt_pkg::FN_READ_AT: begin
				slot = item.position_in;
				if (item.position_in < table_count)
					reply.key_out = table_keys[item.position_in];
				else
					reply.status = skt_pkg::ST_RANGE;
			end
			default: ;
		endcase
		reply.found = hit;
		reply.position = slot[4:0];
		reply.occupancy = table_count[4:0];
		return reply;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (send_calm_items > 0) begin
			send_calm_items--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4)
			send_calm_items = $urandom_range(20, 80);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_req(input logic [2:0] fn, input logic [31:0] k,
			input logic [3:0] idx);
		skt_pkg::req_t item;
		int            gap;
		item.func = fn;
		item.key = k;
		item.position_in = idx;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		table_replies_due.push_back(compute_table_reply(item));
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("reply %0d: %s expected 'h%0h, got 'h%0h", reply_count, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (table_replies_due.size() == 0) begin
				note_mismatch("unexpected beat", '0, rsp.key_out);
			end else begin
				due_reply = table_replies_due.pop_front();
				if (rsp.status !== due_reply.status)
					note_mismatch("status", due_reply.status, rsp.status);
				if (rsp.found !== due_reply.found)
					note_mismatch("found", due_reply.found, rsp.found);
				if (rsp.position !== due_reply.position)
					note_mismatch("position", due_reply.position, rsp.position);
				if (rsp.key_out !== due_reply.key_out)
					note_mismatch("key_out", due_reply.key_out, rsp.key_out);
				if (rsp.occupancy !== due_reply.occupancy)
					note_mismatch("occupancy", due_reply.occupancy, rsp.occupancy);
			end
			reply_count++;
		end
	end

	// response back-pressure: short and long stalls, with stall-free stretches
	always @(negedge clk) begin
		if (calm_cycles > 0) begin
			calm_cycles--;
			rsp_ready <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 5) begin
				calm_cycles = $urandom_range(20, 120);
				rsp_ready <= 1'b1;
			end else if (ready_roll < 60) begin
				rsp_ready <= 1'b1;
			end else if (ready_roll < 92) begin
				hold_cycles = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				hold_cycles = $urandom_range(5, 40);
				rsp_ready <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench failed");
		$finish;
	end

	task automatic test_empty_table();
		send_req(skt_pkg::FN_SEARCH, 32'h0, 4'd0);
		send_req(skt_pkg::FN_REMOVE, 32'hFFFF_FFFF, 4'd0);
		send_req(skt_pkg::FN_READ_AT, 32'h0, 4'd15);
		send_req(FN_FIRST_UNUSED, 32'hFFFF_FFFF, 4'd15);
		send_req(FN_LAST_CODE, 32'h1234_5678, 4'd9);
	endtask

	// duplicates at both key extremes, then fill to capacity and overflow
	task automatic test_fill_to_capacity();
		send_req(skt_pkg::FN_INSERT, 32'hFFFF_FFFF, 4'd0);
		send_req(skt_pkg::FN_INSERT, 32'h0, 4'd0);
		send_req(skt_pkg::FN_INSERT, 32'h0, 4'd0);
		send_req(skt_pkg::FN_INSERT_UNIQUE, 32'h0, 4'd0);
		for (int i = 1; i <= skt_pkg::DEPTH - 3; i++)
			send_req(skt_pkg::FN_INSERT_UNIQUE, 32'h1000_0000 * (i % 4) + i * 7, 4'd0);
		send_req(skt_pkg::FN_INSERT, 32'h8000_0000, 4'd0);
		send_req(skt_pkg::FN_INSERT_UNIQUE, 32'hFFFF_FFFF, 4'd0);
		send_req(skt_pkg::FN_READ_AT, 32'h0, 4'd15);
		send_req(skt_pkg::FN_REMOVE, 32'h0, 4'd0);
	endtask

	function automatic logic [2:0] pick_func(input traffic_mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (roll < 45) return skt_pkg::FN_INSERT;
				if (roll < 70) return skt_pkg::FN_INSERT_UNIQUE;
				if (roll < 80) return skt_pkg::FN_REMOVE;
				if (roll < 90) return skt_pkg::FN_SEARCH;
				if (roll < 98) return skt_pkg::FN_READ_AT;
			end
			MIX_DRAIN: begin
				if (roll < 10) return skt_pkg::FN_INSERT;
				if (roll < 20) return skt_pkg::FN_INSERT_UNIQUE;
				if (roll < 75) return skt_pkg::FN_REMOVE;
				if (roll < 87) return skt_pkg::FN_SEARCH;
				if (roll < 98) return skt_pkg::FN_READ_AT;
			end
			default: begin
				if (roll < 25) return skt_pkg::FN_INSERT;
				if (roll < 40) return skt_pkg::FN_INSERT_UNIQUE;
				if (roll < 65) return skt_pkg::FN_REMOVE;
				if (roll < 80) return skt_pkg::FN_SEARCH;
				if (roll < 97) return skt_pkg::FN_READ_AT;
			end
		endcase
		return 3'($urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE));
	endfunction

	function automatic logic [31:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return key_pool[$urandom_range(0, 7)];
		if (roll < 65 && table_count > 0)
			return table_keys[$urandom_range(0, table_count - 1)];
		if (roll < 75 && table_count > 0)
			return table_keys[$urandom_range(0, table_count - 1)] +
				(($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF);
		if (roll < 80)
			return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom();
	endfunction

	task automatic test_random_traffic();
		traffic_mix_t mix;
		for (int b = 0; b < BATCHES; b++) begin
			mix = traffic_mix_t'($urandom_range(0, 2));
			for (int i = 0; i < 8; i++)
				key_pool[i] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom();
			for (int i = 0; i < BATCH_ITEMS; i++)
				send_req(pick_func(mix), pick_key(), 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		table_count = 0;
		fail_count = 0;
		reply_count = 0;
		hold_cycles = 0;
		calm_cycles = 0;
		send_calm_items = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_fill_to_capacity();
		test_random_traffic();
		req_valid <= 1'b0;
		while (table_replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && table_replies_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
